// ----- hdl/pbsf_pkg.sv -----
// Shared types, constants and functions for the protobuf status field decoder.
`timescale 1ns / 1ps
`default_nettype none
package pbsf_pkg;

  typedef enum logic [2:0] {
    PH_TAG, PH_VARINT, PH_FIXED32, PH_SKIP, PH_LEN, PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {STOP_RUN, STOP_KEEP, STOP_DROP} stop_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [3:0] K_SOC     = 4'd0;
  localparam logic [3:0] K_IN_W    = 4'd1;
  localparam logic [3:0] K_OUT_W   = 4'd2;
  localparam logic [3:0] K_AC_IN   = 4'd3;
  localparam logic [3:0] K_AC_OUT  = 4'd4;
  localparam logic [3:0] K_BATT    = 4'd5;
  localparam logic [3:0] K_AC_PRES = 4'd6;
  localparam logic [3:0] K_DSG_MIN = 4'd7;
  localparam logic [3:0] K_CHG_MIN = 4'd8;
  localparam logic [3:0] K_TEMP    = 4'd9;
  localparam logic [3:0] K_MIN_SOC = 4'd10;
  localparam logic [3:0] K_MAX_SOC = 4'd11;
  localparam logic [3:0] K_BACKUP  = 4'd12;
  localparam logic [3:0] K_RESERVE = 4'd13;
  localparam logic [3:0] K_ERROR   = 4'd14;
  localparam logic [3:0] K_SUMMARY = 4'd15;

  localparam logic [31:0] F_SOC     = 32'd262;
  localparam logic [31:0] F_IN_W    = 32'd3;
  localparam logic [31:0] F_OUT_W   = 32'd4;
  localparam logic [31:0] F_AC_IN   = 32'd54;
  localparam logic [31:0] F_AC_OUT  = 32'd368;
  localparam logic [31:0] F_BATT    = 32'd158;
  localparam logic [31:0] F_AC_PRES = 32'd202;
  localparam logic [31:0] F_DSG_MIN = 32'd268;
  localparam logic [31:0] F_CHG_MIN = 32'd269;
  localparam logic [31:0] F_TEMP    = 32'd259;
  localparam logic [31:0] F_MIN_SOC = 32'd271;
  localparam logic [31:0] F_MAX_SOC = 32'd270;
  localparam logic [31:0] F_BACKUP  = 32'd7;
  localparam logic [31:0] F_RESERVE = 32'd8;
  localparam logic [31:0] F_ERROR   = 32'd1;

  localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_INF = 32'h7F80_0000;
  localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0]         kind;
    logic [31:0]        field_value;
    logic [15:0]        matched_count;
    logic               charging;
    logic               derived_applied;
    logic signed [31:0] soc_low;
    logic               last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } push_t;

  function automatic logic [63:0] shl7(input logic [6:0] d, input logic [3:0] c);
    logic [6:0] a;
    a = 7'(c) * 7'd7;
    return 64'(d) << a;
  endfunction

  function automatic logic [31:0] round_soc(input logic [31:0] bits);
    logic [7:0]  e;
    logic [23:0] m;
    logic [7:0]  sh;
    logic [24:0] sum;
    logic [31:0] mag;
    e = bits[30:23];
    m = {1'b1, bits[22:0]};
    sh = 8'd150 - e;
    sum = 25'(m) + (25'd1 << (sh - 8'd1));
    mag = 32'(sum >> sh);
    if (e >= 8'd150) mag = 32'(m) << (e - 8'd150);
    if (e == 8'hFF && bits[22:0] != '0) return '0;
    if (e >= 8'd158) return bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (e == 8'd0) return '0;
    if (e < 8'd150 && sh > 8'd24) return '0;
    return bits[31] ? 32'd0 - mag : mag;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pbsf_ifs.sv -----
// Channel interfaces for message bytes, configuration and results.
`timescale 1ns / 1ps
`default_nettype none
interface pbsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;
  modport source (output valid, byte_in, last_byte, input ready);
  modport sink (input valid, byte_in, last_byte, output ready);
endinterface

interface pbsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] soc_low_floor;
  modport source (output valid, soc_low_floor, input ready);
  modport sink (input valid, soc_low_floor, output ready);
endinterface

interface pbsf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [31:0]        field_value;
  logic [15:0]        matched_count;
  logic               charging;
  logic               derived_applied;
  logic signed [31:0] soc_low;
  logic               last_of_run;
  modport source (output valid, kind, field_value, matched_count, charging,
                  derived_applied, soc_low, last_of_run, input ready);
  modport sink (input valid, kind, field_value, matched_count, charging,
                derived_applied, soc_low, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hdl/pbsf_front.sv -----
// Front end: wire format parser, field matching and summary generation.
`timescale 1ns / 1ps
`default_nettype none
module pbsf_front import pbsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  pbsf_in_if.sink    in_ch,
  pbsf_cfg_if.sink   cfg,
  input  wire logic  q_ready,
  output push_t      push
);

  phase_t             phase, phase_next;
  stop_t              stop_mode, stop_mode_next;
  logic [3:0]         cnt, cnt_next;
  logic [63:0]        acc, acc_next;
  logic [31:0]        fnum, fnum_next;
  logic [2:0]         wtype, wtype_next;
  logic [63:0]        skip, skip_next;
  logic [15:0]        matched, matched_next;
  logic               dl_valid, dl_valid_next;
  logic [31:0]        dl, dl_next;
  logic               ac, ac_next;
  logic [31:0]        batt, batt_next;
  logic signed [31:0] soc_low, soc_low_next;

  logic        fire, fin, fmatch, fixed, der, chg, drop;
  logic [63:0] vacc, facc, raw, vint, sk;
  logic [3:0]  cnt_inc;
  logic [3:0]  fkind;
  logic [31:0] fval;
  res_t        summ, fres;

  assign in_ch.ready = q_ready;
  assign cfg.ready = 1'b1;
  assign fire = in_ch.valid && q_ready;

  always_comb begin
    phase_next = phase;
    stop_mode_next = stop_mode;
    cnt_next = cnt;
    acc_next = acc;
    fnum_next = fnum;
    wtype_next = wtype;
    skip_next = skip;
    matched_next = matched;
    dl_valid_next = dl_valid;
    dl_next = dl;
    ac_next = ac;
    batt_next = batt;
    soc_low_next = soc_low;
    fin = 1'b0;
    raw = acc;
    fmatch = 1'b0;
    fkind = K_SUMMARY;
    fval = '0;
    der = 1'b0;
    chg = 1'b0;
    drop = 1'b0;
    fixed = 1'b0;
    vint = '0;
    vacc = acc | shl7(in_ch.byte_in[6:0], cnt);
    facc = acc | (64'(in_ch.byte_in) << {cnt[1:0], 3'b000});
    cnt_inc = cnt + 4'd1;
    sk = (skip != '0) ? skip - 64'd1 : skip;
    push = '0;

    if (fire) begin
      unique case (phase)
        PH_TAG, PH_VARINT, PH_LEN: begin
          acc_next = vacc;
          if (in_ch.byte_in[7]) begin
            cnt_next = cnt_inc;
            if (cnt_inc >= MAX_VARINT_BYTES) begin
              phase_next = PH_STOPPED;
              stop_mode_next = (phase == PH_TAG) ? STOP_KEEP : STOP_DROP;
            end
          end else begin
            cnt_next = '0;
            acc_next = '0;
            if (phase == PH_TAG) begin
              fnum_next = vacc[34:3];
              wtype_next = vacc[2:0];
              unique case (vacc[2:0])
                WT_VARINT:  phase_next = PH_VARINT;
                WT_FIXED32: phase_next = PH_FIXED32;
                WT_FIXED64: begin
                  phase_next = PH_SKIP;
                  skip_next = 64'd8;
                end
                WT_LEN:     phase_next = PH_LEN;
                default: begin
                  phase_next = PH_STOPPED;
                  stop_mode_next = STOP_DROP;
                end
              endcase
            end else if (phase == PH_VARINT) begin
              fin = 1'b1;
              raw = vacc;
              phase_next = PH_TAG;
            end else begin
              skip_next = vacc;
              phase_next = (vacc == '0) ? PH_TAG : PH_SKIP;
            end
          end
        end
        PH_FIXED32: begin
          acc_next = facc;
          cnt_next = cnt_inc;
          if (cnt[1:0] == 2'd3) begin
            fin = 1'b1;
            raw = facc;
            acc_next = '0;
            cnt_next = '0;
            phase_next = PH_TAG;
          end
        end
        PH_SKIP: begin
          skip_next = sk;
          if (sk == '0) phase_next = PH_TAG;
        end
        default: ;
      endcase

      fixed = (wtype == WT_FIXED32);
      vint = fixed ? 64'd0 : raw;
      if (fin) begin
        fmatch = 1'b1;
        unique case (fnum)
          F_SOC:     begin fkind = K_SOC;    fval = raw[31:0]; fmatch = fixed; end
          F_IN_W:    begin fkind = K_IN_W;   fval = raw[31:0]; fmatch = fixed; end
          F_OUT_W:   begin fkind = K_OUT_W;  fval = raw[31:0]; fmatch = fixed; end
          F_AC_IN:   begin fkind = K_AC_IN;  fval = raw[31:0]; fmatch = fixed; end
          F_AC_OUT:  begin fkind = K_AC_OUT; fval = raw[31:0]; fmatch = fixed; end
          F_BATT: begin
            fkind = K_BATT;
            fval = raw[31:0];
            fmatch = fixed;
            if (fixed) batt_next = raw[31:0];
          end
          F_AC_PRES: begin
            fkind = K_AC_PRES;
            ac_next = (vint != '0);
            fval = {31'd0, vint != '0};
          end
          F_DSG_MIN: begin fkind = K_DSG_MIN; fval = vint[31:0]; end
          F_CHG_MIN: begin fkind = K_CHG_MIN; fval = vint[31:0]; end
          F_TEMP:    begin fkind = K_TEMP;    fval = vint[31:0]; end
          F_MIN_SOC: begin
            fkind = K_MIN_SOC;
            fval = vint[31:0];
            dl_valid_next = 1'b1;
            dl_next = vint[31:0];
          end
          F_MAX_SOC: begin fkind = K_MAX_SOC; fval = vint[31:0]; end
          F_BACKUP:  begin fkind = K_BACKUP;  fval = {31'd0, vint != '0}; end
          F_RESERVE: begin fkind = K_RESERVE; fval = vint[31:0]; end
          F_ERROR:   begin fkind = K_ERROR;   fval = vint[31:0]; end
          default:   fmatch = 1'b0;
        endcase
        if (fmatch && matched != 16'hFFFF) matched_next = matched + 16'd1;
      end

      if (in_ch.last_byte) begin
        drop = (stop_mode_next == STOP_DROP) ||
               (phase_next != PH_TAG && phase_next != PH_STOPPED);
        der = !drop && (matched_next != '0);
        chg = der && ac_next && (batt_next > FLOAT_ONE) && (batt_next <= FLOAT_INF);
        if (der && dl_valid_next && !dl_next[31] && $signed(dl_next) > soc_low)
          soc_low_next = $signed(dl_next);
      end
    end

    fres = '0;
    fres.kind = fkind;
    fres.field_value = fval;
    summ = '0;
    summ.kind = K_SUMMARY;
    summ.matched_count = matched_next;
    summ.charging = chg;
    summ.derived_applied = der;
    summ.soc_low = soc_low_next;
    summ.last_of_run = 1'b1;

    if (fire) begin
      push.n = 2'(fmatch) + 2'(in_ch.last_byte);
      push.e0 = fmatch ? fres : summ;
      push.e1 = summ;
      if (in_ch.last_byte) begin
        phase_next = PH_TAG;
        stop_mode_next = STOP_RUN;
        cnt_next = '0;
        acc_next = '0;
        fnum_next = '0;
        wtype_next = '0;
        skip_next = '0;
        matched_next = '0;
        dl_valid_next = 1'b0;
        dl_next = '0;
      end
    end

    if (cfg.valid && soc_low < $signed(32'(cfg.soc_low_floor)))
      soc_low_next = $signed(32'(cfg.soc_low_floor));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TAG;
      stop_mode <= STOP_RUN;
      cnt <= '0;
      acc <= '0;
      fnum <= '0;
      wtype <= '0;
      skip <= '0;
      matched <= '0;
      dl_valid <= 1'b0;
      dl <= '0;
      ac <= 1'b0;
      batt <= '0;
      soc_low <= '0;
    end else begin
      phase <= phase_next;
      stop_mode <= stop_mode_next;
      cnt <= cnt_next;
      acc <= acc_next;
      fnum <= fnum_next;
      wtype <= wtype_next;
      skip <= skip_next;
      matched <= matched_next;
      dl_valid <= dl_valid_next;
      dl <= dl_next;
      ac <= ac_next;
      batt <= batt_next;
      soc_low <= soc_low_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pbsf_queue.sv -----
// Short result queue taking up to two words per cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none
module pbsf_queue import pbsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       space2,
  output logic       nonempty,
  output res_t       head,
  input  wire logic  pop
);

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   count;

  assign space2 = (count <= (QAW+1)'(QDEPTH - 2));
  assign nonempty = (count != '0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.e0;
    if (push.n == 2'd2) mem[wp + QAW'(1)] <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + QAW'(push.n);
      if (pop) rp <= rp + QAW'(1);
      count <= count + (QAW+1)'(push.n) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pbsf_back.sv -----
// Back end: output register that finishes state-of-charge rounding.
`timescale 1ns / 1ps
`default_nettype none
module pbsf_back import pbsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  nonempty,
  input  wire res_t  head,
  output logic       pop,
  pbsf_out_if.source out_ch
);

  logic valid;
  res_t r, r_next;

  assign pop = nonempty && (!valid || out_ch.ready);

  always_comb begin
    r_next = head;
    if (head.kind == K_SOC && !head.last_of_run)
      r_next.field_value = round_soc(head.field_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || out_ch.ready) begin
      valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r <= r_next;
    end
  end

  assign out_ch.valid = valid;
  assign out_ch.kind = r.kind;
  assign out_ch.field_value = r.field_value;
  assign out_ch.matched_count = r.matched_count;
  assign out_ch.charging = r.charging;
  assign out_ch.derived_applied = r.derived_applied;
  assign out_ch.soc_low = r.soc_low;
  assign out_ch.last_of_run = r.last_of_run;

endmodule
`default_nettype wire

// ----- hdl/protobuf_status_field_decoder_core.sv -----
// Top level of the protobuf status field decoder.
// Takes one byte per cycle while the queue has room for two result words.
// A field word passes through the result queue and the output register;
// the summary word of the same byte follows it; one result leaves per cycle while ready.
// Synchronous reset clears the parser, the persistent status and the queue.
`timescale 1ns / 1ps
`default_nettype none
module protobuf_status_field_decoder_core import pbsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  pbsf_in_if.sink    in_ch,
  pbsf_cfg_if.sink   cfg,
  pbsf_out_if.source out_ch
);

  push_t push;
  logic  space2, nonempty, pop;
  res_t  head;

  pbsf_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .q_ready(space2), .push(push)
  );

  pbsf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .space2(space2), .nonempty(nonempty),
    .head(head), .pop(pop)
  );

  pbsf_back u_back (
    .clk(clk), .rst(rst), .nonempty(nonempty), .head(head), .pop(pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// ----- hdl/pbsf_checker.sv -----
// Port level checks for the decoder top level and their bind.
`timescale 1ns / 1ps
`default_nettype none
module pbsf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [15:0] out_count,
  input wire logic        out_chg,
  input wire logic        out_der,
  input wire logic [31:0] out_low,
  input wire logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("Stalled result word changed.");

  a_field_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_count == '0 && !out_der && out_low == '0)
    else $error("Field word carries summary data.");

  a_der_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_der |-> out_last && out_count != '0)
    else $error("Derived flag outside a summary with matches.");

  a_chg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_chg |-> out_der)
    else $error("Charging flag without derived update.");

endmodule

bind protobuf_status_field_decoder_core pbsf_checker u_pbsf_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_value(out_ch.field_value), .out_count(out_ch.matched_count),
  .out_chg(out_ch.charging), .out_der(out_ch.derived_applied),
  .out_low(out_ch.soc_low), .out_last(out_ch.last_of_run)
);
`default_nettype wire

// ----- tb/sv/pbsf_status_checker.sv -----
// Checker that predicts the decoder's result words and compares them with the output channel.
`timescale 1ns / 1ps
`default_nettype none
module pbsf_status_checker import pbsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pbsf_in_if        in_ch,
  pbsf_cfg_if       cfg,
  pbsf_out_if       out_ch,
  output int        failures,
  output int        pending
);

  res_t        expected_words[$];
  phase_t      ph;
  stop_t       mode;
  logic [3:0]  cnt;
  logic [63:0] acc;
  logic [31:0] fnum;
  logic [2:0]  wt;
  logic [63:0] skip_left;
  logic [15:0] nmatch;
  logic        dev_low_seen;
  logic [31:0] dev_low;
  logic        ac_on;
  logic [31:0] batt_bits;
  logic [31:0] low_state;

  function automatic logic [31:0] soc_to_int(input logic [31:0] bits);
    logic [7:0]  e;
    logic [31:0] mm;
    logic [31:0] mag;
    int          sh;
    e = bits[30:23];
    mm = {8'd0, 1'b1, bits[22:0]};
    if (e == 8'hFF && bits[22:0] != 0) return 0;
    if (e >= 8'd158) return bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (e == 0) return 0;
    if (e >= 8'd150) begin
      mag = mm << (e - 8'd150);
    end else begin
      sh = 150 - e;
      if (sh > 24) return 0;
      mag = (mm + (32'd1 << (sh - 1))) >> sh;
    end
    return bits[31] ? 32'd0 - mag : mag;
  endfunction

  function automatic void clear_msg();
    ph = PH_TAG;
    mode = STOP_RUN;
    cnt = 0;
    acc = 0;
    fnum = 0;
    wt = 0;
    skip_left = 0;
    nmatch = 0;
    dev_low_seen = 0;
    dev_low = 0;
  endfunction

  function automatic void field_done(input logic [63:0] raw);
    res_t        r;
    logic        fixed;
    logic [63:0] vi;
    logic [31:0] lo;
    logic [3:0]  k;
    logic [31:0] v;
    logic        hit;
    fixed = (wt == WT_FIXED32);
    vi = fixed ? 64'd0 : raw;
    lo = vi[31:0];
    hit = 1;
    v = lo;
    k = K_SUMMARY;
    case (fnum)
      F_SOC:     begin hit = fixed; k = K_SOC; v = soc_to_int(raw[31:0]); end
      F_IN_W:    begin hit = fixed; k = K_IN_W; v = raw[31:0]; end
      F_OUT_W:   begin hit = fixed; k = K_OUT_W; v = raw[31:0]; end
      F_AC_IN:   begin hit = fixed; k = K_AC_IN; v = raw[31:0]; end
      F_AC_OUT:  begin hit = fixed; k = K_AC_OUT; v = raw[31:0]; end
      F_BATT: begin
        hit = fixed;
        k = K_BATT;
        v = raw[31:0];
        if (fixed) batt_bits = raw[31:0];
      end
      F_AC_PRES: begin k = K_AC_PRES; ac_on = (vi != 0); v = {31'd0, ac_on}; end
      F_DSG_MIN: k = K_DSG_MIN;
      F_CHG_MIN: k = K_CHG_MIN;
      F_TEMP:    k = K_TEMP;
      F_MIN_SOC: begin k = K_MIN_SOC; dev_low_seen = 1; dev_low = lo; end
      F_MAX_SOC: k = K_MAX_SOC;
      F_BACKUP:  begin k = K_BACKUP; v = {31'd0, vi != 0}; end
      F_RESERVE: k = K_RESERVE;
      F_ERROR:   k = K_ERROR;
      default:   hit = 0;
    endcase
    if (!hit) return;
    if (nmatch != 16'hFFFF) nmatch++;
    r = '0;
    r.kind = k;
    r.field_value = v;
    expected_words.push_back(r);
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic lastb);
    res_t r;
    logic drop;
    case (ph)
      PH_TAG, PH_VARINT, PH_LEN: begin
        acc = acc | (64'(b[6:0]) << (7 * cnt));
        if (b[7]) begin
          cnt++;
          if (cnt >= MAX_VARINT_BYTES) begin
            mode = (ph == PH_TAG) ? STOP_KEEP : STOP_DROP;
            ph = PH_STOPPED;
          end
        end else begin
          cnt = 0;
          if (ph == PH_TAG) begin
            fnum = acc[34:3];
            wt = acc[2:0];
            acc = 0;
            if (wt == WT_VARINT) ph = PH_VARINT;
            else if (wt == WT_FIXED32) ph = PH_FIXED32;
            else if (wt == WT_FIXED64) begin ph = PH_SKIP; skip_left = 8; end
            else if (wt == WT_LEN) ph = PH_LEN;
            else begin mode = STOP_DROP; ph = PH_STOPPED; end
          end else if (ph == PH_VARINT) begin
            field_done(acc);
            acc = 0;
            ph = PH_TAG;
          end else begin
            skip_left = acc;
            acc = 0;
            ph = (skip_left == 0) ? PH_TAG : PH_SKIP;
          end
        end
      end
      PH_FIXED32: begin
        acc = acc | (64'(b) << (8 * cnt[1:0]));
        cnt++;
        if (cnt >= 4) begin
          field_done(acc);
          acc = 0;
          cnt = 0;
          ph = PH_TAG;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) ph = PH_TAG;
      end
      default: ;
    endcase
    if (lastb) begin
      drop = (mode == STOP_DROP) || (ph != PH_TAG && ph != PH_STOPPED);
      r = '0;
      r.kind = K_SUMMARY;
      r.matched_count = nmatch;
      r.last_of_run = 1;
      if (!drop && nmatch != 0) begin
        r.derived_applied = 1;
        r.charging = ac_on && batt_bits > FLOAT_ONE && batt_bits <= FLOAT_INF;
        if (dev_low_seen && !dev_low[31] && $signed(dev_low) > $signed(low_state))
          low_state = dev_low;
      end
      r.soc_low = low_state;
      expected_words.push_back(r);
      clear_msg();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endfunction

  assign pending = expected_words.size();

  initial begin
    failures = 0;
    clear_msg();
    ac_on = 0;
    batt_bits = 0;
    low_state = 0;
  end

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      clear_msg();
      ac_on = 0;
      batt_bits = 0;
      low_state = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if ($signed(low_state) < $signed({25'd0, cfg.soc_low_floor}))
          low_state = 32'(cfg.soc_low_floor);
      end
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.byte_in, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d", out_ch.kind);
          failures++;
        end else begin
          e = expected_words.pop_front();
          check_field("kind", 32'(e.kind), 32'(out_ch.kind));
          check_field("field_value", e.field_value, out_ch.field_value);
          check_field("matched_count", 32'(e.matched_count), 32'(out_ch.matched_count));
          check_field("charging", 32'(e.charging), 32'(out_ch.charging));
          check_field("derived_applied", 32'(e.derived_applied),
                      32'(out_ch.derived_applied));
          check_field("soc_low", e.soc_low, out_ch.soc_low);
          check_field("last_of_run", 32'(e.last_of_run), 32'(out_ch.last_of_run));
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_protobuf_status_field_decoder_core.sv -----
// Testbench top: drives message bytes, floor writes and output stalls, then gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_protobuf_status_field_decoder_core import pbsf_pkg::*;;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 0;
  logic rst = 1;
  int   failures;
  int   pending;
  int   idle_cycles = 0;
  int   out_words = 0;
  int   bytes_sent = 0;
  logic [7:0] msg[$];

  pbsf_in_if  in_ch();
  pbsf_cfg_if cfg();
  pbsf_out_if out_ch();

  protobuf_status_field_decoder_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
  );

  pbsf_status_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch),
    .failures(failures), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.byte_in = 0;
    in_ch.last_byte = 0;
    cfg.valid = 0;
    cfg.soc_low_floor = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (cfg.valid && cfg.ready) ||
        (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (out_ch.valid && out_ch.ready) out_words <= out_words + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** protobuf_status_field_decoder_core: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: random ready stretches, plus one long hold-off so the input backs up.
  initial begin
    int  left;
    logic rdy;
    bit  held;
    held = 0;
    left = 0;
    rdy = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && out_words >= 150) begin
        held = 1;
        out_ch.ready = 0;
        repeat (400) @(negedge clk);
      end
      if (left == 0) begin
        if ($urandom_range(0, 99) < 60) begin
          rdy = 1;
          left = $urandom_range(1, 30);
        end else begin
          rdy = 0;
          left = pick_gap() + 1;
        end
      end
      left--;
      out_ch.ready = rdy;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lastb);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 0;
    end
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.byte_in = b;
    in_ch.last_byte = lastb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  task automatic write_floor(input logic [6:0] value);
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg.valid = 1;
    cfg.soc_low_floor = value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  function automatic void put_varint(input logic [63:0] v);
    do begin
      msg.push_back({v > 64'h7F, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void put_tag(input logic [63:0] fn, input logic [2:0] w);
    put_varint((fn << 3) | 64'(w));
  endfunction

  function automatic void put_fixed32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) msg.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 11))
      0: return 32'h7F80_0000;
      1: return 32'hFF80_0000;
      2: return 32'h7FC0_0000;
      3: return {1'($urandom_range(0, 1)), 31'd0};
      4: return 32'h0000_0001;
      5: return 32'h3F00_0000;
      6: return {1'($urandom_range(0, 1)), 31'h3FC0_0000};
      7: return FLOAT_ONE + $urandom_range(0, 1);
      8: return $urandom;
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 165)),
                       23'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] rand_u64();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic void put_payload(input logic [2:0] w, input logic [63:0] fn);
    int n;
    case (w)
      WT_VARINT: put_varint(fn == F_AC_PRES || fn == F_BACKUP ?
                            64'($urandom_range(0, 1)) : rand_u64());
      WT_FIXED32: put_fixed32(rand_float());
      WT_FIXED64: for (int i = 0; i < 8; i++) msg.push_back(8'($urandom));
      WT_LEN: begin
        n = $urandom_range(0, 6);
        put_varint(64'(n));
        for (int i = 0; i < n; i++) msg.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  function automatic void put_random_field();
    logic [31:0] known[15];
    logic [63:0] fn;
    logic [2:0]  w;
    int          idx;
    int          r;
    known = '{F_SOC, F_IN_W, F_OUT_W, F_AC_IN, F_AC_OUT, F_BATT, F_AC_PRES, F_DSG_MIN,
              F_CHG_MIN, F_TEMP, F_MIN_SOC, F_MAX_SOC, F_BACKUP, F_RESERVE, F_ERROR};
    r = $urandom_range(0, 99);
    idx = $urandom_range(0, 14);
    if (r < 75) fn = 64'(known[idx]);
    else if (r < 92) fn = 64'($urandom_range(0, 400));
    else fn = {29'd0, 3'($urandom_range(1, 7)), known[idx]};
    r = $urandom_range(0, 99);
    if (idx <= 5 && fn[31:0] == known[idx]) w = (r < 85) ? WT_FIXED32 : WT_VARINT;
    else if (r < 70) w = WT_VARINT;
    else if (r < 85) w = WT_FIXED32;
    else if (r < 93) w = WT_FIXED64;
    else w = WT_LEN;
    put_tag(fn, w);
    put_payload(w, fn);
  endfunction

  task automatic directed();
    put_tag(F_SOC, WT_FIXED32); put_fixed32(32'h3F00_0000);
    put_tag(F_AC_PRES, WT_VARINT); put_varint(1);
    put_tag(F_BATT, WT_FIXED32); put_fixed32(32'h4000_0000);
    put_tag(F_MIN_SOC, WT_VARINT); put_varint(30);
    send_msg();
    put_tag(F_SOC, WT_FIXED32); put_fixed32(32'hC020_0000);
    put_tag(F_SOC, WT_FIXED32); put_fixed32(32'h7FC0_0000);
    put_tag(F_SOC, WT_FIXED32); put_fixed32(32'hFF80_0000);
    put_tag(F_IN_W, WT_VARINT); put_varint(5);
    put_tag(F_TEMP, WT_FIXED32); put_fixed32(32'hFFFF_FFFF);
    put_tag(99, WT_FIXED64); put_payload(WT_FIXED64, 99);
    put_tag(99, WT_LEN); put_varint(0);
    put_tag({29'd0, 3'd7, F_ERROR}, WT_VARINT); put_varint(64'hFFFF_FFFF_FFFF_FFFF);
    put_tag(F_MIN_SOC, WT_VARINT); put_varint(64'hFFFF_FFFF);
    send_msg();
    put_tag(F_BACKUP, WT_VARINT); put_varint(2);
    put_tag(F_MAX_SOC, 3'd3);
    send_msg();
    put_tag(F_RESERVE, WT_VARINT);
    for (int i = 0; i < 10; i++) msg.push_back(8'hFF);
    msg.push_back(8'h01);
    send_msg();
    put_tag(F_CHG_MIN, WT_VARINT); put_varint(7);
    for (int i = 0; i < 10; i++) msg.push_back(8'h80);
    send_msg();
    put_tag(F_DSG_MIN, WT_VARINT); put_varint(3);
    msg.push_back(8'h80);
    send_msg();
    put_tag(F_AC_IN, WT_FIXED32); msg.push_back(8'h12);
    send_msg();
    put_tag(F_MIN_SOC, WT_VARINT); put_varint(100);
    send_msg();
  endtask

  initial begin
    int r;
    int nf;
    int cut;
    int next_cfg;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_floor(7'd20);
    directed();
    write_floor(7'd0);
    write_floor(7'd100);
    next_cfg = 400;
    while (bytes_sent < 1600) begin
      if (bytes_sent >= next_cfg) begin
        write_floor(($urandom_range(0, 3) == 0) ? 7'd127 : 7'($urandom));
        next_cfg += 400;
      end
      r = $urandom_range(0, 99);
      nf = $urandom_range(1, 6);
      for (int i = 0; i < nf; i++) put_random_field();
      if (r < 70) begin
      end else if (r < 80) begin
        cut = $urandom_range(1, msg.size());
        while (msg.size() > cut) void'(msg.pop_back());
      end else if (r < 88) begin
        msg.delete();
        repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
      end else if (r < 92) begin
        put_tag(64'($urandom_range(1, 300)),
                3'($urandom_range(0, 1) ? $urandom_range(3, 4) : $urandom_range(6, 7)));
        put_random_field();
      end else if (r < 96) begin
        put_tag(F_TEMP, WT_VARINT);
        repeat (10) msg.push_back(8'h80 | 8'($urandom));
        put_random_field();
      end else begin
        repeat (10) msg.push_back(8'h80 | 8'($urandom));
        msg.push_back(8'($urandom));
      end
      send_msg();
    end
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("** protobuf_status_field_decoder_core: PASSED **");
    else
      $display("** protobuf_status_field_decoder_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/pbsf_pkg.sv
hdl/pbsf_ifs.sv
hdl/pbsf_front.sv
hdl/pbsf_queue.sv
hdl/pbsf_back.sv
hdl/protobuf_status_field_decoder_core.sv
hdl/pbsf_checker.sv
tb/sv/pbsf_status_checker.sv
tb/sv/tb_protobuf_status_field_decoder_core.sv
